// ===== sv/bfi_pkg.sv =====
// ----------------------------------------------------------------------------
// bfi_pkg: shared types and constants
// Request layout, weight bundle and fixed widths of the barycentric
// field interpolator.
// ----------------------------------------------------------------------------
package bfi_pkg;

  localparam int DataW       = 32;
  localparam int FracBitsDef = 16;
  localparam int InDataW     = 4 * DataW;
  localparam int InUserW     = 4;
  localparam int OutDataW    = 7 * DataW;

  // the largest normalized magnitude sits in [2^29, 2^30)
  localparam int NormW   = 30;
  localparam int NormPos = 29;
  localparam int SqW     = 2 * NormW + 2;
  localparam int LenW    = SqW / 2;

  localparam logic [1:0] OpLoadRow    = 2'd0;
  localparam logic [1:0] OpLoadVertex = 2'd1;
  localparam logic [1:0] OpQuery      = 2'd2;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] slot;
    word_t      a;
    word_t      b;
    word_t      c;
    word_t      d;
  } item_t;

  typedef struct packed {
    logic            in_tet;
    word_t [3:0]     w;
  } wres_t;

  typedef struct packed {
    word_t [2:0] f;
    wres_t       wr;
  } ores_t;

endpackage

// ===== sv/bfi_weight.sv =====
// ----------------------------------------------------------------------------
// bfi_weight: matrix store and barycentric weights
// Two stages: point times matrix products, then sum and saturate.
// ----------------------------------------------------------------------------
module bfi_weight #(
  parameter int FRAC_BITS = bfi_pkg::FracBitsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           v_in,
  input  bfi_pkg::item_t item_in,
  output logic           v_out,
  output bfi_pkg::wres_t wr_out,
  output bfi_pkg::item_t item_out
);
  import bfi_pkg::*;

  localparam int PW = 2 * DataW;
  localparam int TW = PW - FRAC_BITS;
  localparam int SW = TW + 2;

  word_t                mat [4][4];
  word_t                pt  [3];
  logic signed [PW-1:0] prod [4][3];
  word_t                r3  [4];
  logic                 v1;
  item_t                item1;
  logic signed [SW-1:0] sum [4];
  logic [SW-DataW:0]    hi  [4];
  word_t                w   [4];

  assign pt[0] = item_in.a;
  assign pt[1] = item_in.b;
  assign pt[2] = item_in.c;

  // row store, written in request order at the read stage
  always_ff @(posedge clk) begin
    if (en && v_in && item_in.op == OpLoadRow) begin
      mat[item_in.slot][0] <= item_in.a;
      mat[item_in.slot][1] <= item_in.b;
      mat[item_in.slot][2] <= item_in.c;
      mat[item_in.slot][3] <= item_in.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v1    <= v_in && (item_in.op == OpLoadVertex || item_in.op == OpQuery);
      v_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1 <= item_in;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PW'(mat[i][j]) * PW'(pt[j]);
        end
        r3[i] <= mat[i][3];
      end
    end
  end

  // floor shift of each product, exact sum, saturate to 32 bits
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum[i] = SW'(TW'(prod[i][0] >>> FRAC_BITS)) + SW'(TW'(prod[i][1] >>> FRAC_BITS))
             + SW'(TW'(prod[i][2] >>> FRAC_BITS)) + SW'(r3[i]);
      hi[i]  = sum[i][SW-1:DataW-1];
      if (&hi[i] || ~|hi[i]) begin
        w[i] = sum[i][DataW-1:0];
      end else if (sum[i][SW-1]) begin
        w[i] = {1'b1, {(DataW-1){1'b0}}};
      end else begin
        w[i] = {1'b0, {(DataW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out      <= item1;
      wr_out.in_tet <= ~(w[0][DataW-1] | w[1][DataW-1] | w[2][DataW-1] | w[3][DataW-1]);
      for (int i = 0; i < 4; i++) begin
        wr_out.w[i] <= w[i];
      end
    end
  end

endmodule

// ===== sv/bfi_blend.sv =====
// ----------------------------------------------------------------------------
// bfi_blend: vertex store and weighted blends
// Two stages: direction and force products, then exact sums.
// ----------------------------------------------------------------------------
module bfi_blend #(
  parameter int FRAC_BITS = bfi_pkg::FracBitsDef
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    v_in,
  input  bfi_pkg::wres_t                          wr_in,
  input  bfi_pkg::item_t                          item_in,
  output logic                                    v_out,
  output logic signed [2*bfi_pkg::DataW-FRAC_BITS+1:0] s_out [3],
  output logic signed [2*bfi_pkg::DataW-FRAC_BITS+1:0] f_out,
  output bfi_pkg::wres_t                          wr_out
);
  import bfi_pkg::*;

  localparam int PW = 2 * DataW;
  localparam int TW = PW - FRAC_BITS;
  localparam int SW = TW + 2;

  word_t                dir [4][3];
  word_t                frc [4];
  logic signed [PW-1:0] pd  [4][3];
  logic signed [PW-1:0] pf  [4];
  logic                 v3;
  wres_t                wr3;

  always_ff @(posedge clk) begin
    if (en && v_in && item_in.op == OpLoadVertex) begin
      dir[item_in.slot][0] <= item_in.a;
      dir[item_in.slot][1] <= item_in.b;
      dir[item_in.slot][2] <= item_in.c;
      frc[item_in.slot]    <= item_in.d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      v3    <= v_in && item_in.op == OpQuery;
      v_out <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr3 <= wr_in;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          pd[i][k] <= PW'(dir[i][k]) * PW'(wr_in.w[i]);
        end
        pf[i] <= PW'(frc[i]) * PW'(wr_in.w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_out <= wr3;
      for (int k = 0; k < 3; k++) begin
        s_out[k] <= SW'(TW'(pd[0][k] >>> FRAC_BITS)) + SW'(TW'(pd[1][k] >>> FRAC_BITS))
                  + SW'(TW'(pd[2][k] >>> FRAC_BITS)) + SW'(TW'(pd[3][k] >>> FRAC_BITS));
      end
      f_out <= SW'(TW'(pf[0] >>> FRAC_BITS)) + SW'(TW'(pf[1] >>> FRAC_BITS))
             + SW'(TW'(pf[2] >>> FRAC_BITS)) + SW'(TW'(pf[3] >>> FRAC_BITS));
    end
  end

endmodule

// ===== sv/bfi_norm.sv =====
// ----------------------------------------------------------------------------
// bfi_norm: magnitude normalization and sum of squares
// Six stages: abs/max, chunk scan, leading one, shift, squares, sum.
// ----------------------------------------------------------------------------
module bfi_norm #(
  parameter int FRAC_BITS = bfi_pkg::FracBitsDef
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         v_in,
  input  logic signed [2*bfi_pkg::DataW-FRAC_BITS+1:0] s_in [3],
  input  logic signed [2*bfi_pkg::DataW-FRAC_BITS+1:0] f_in,
  input  bfi_pkg::wres_t                               wr_in,
  output logic                                         v_out,
  output logic [bfi_pkg::SqW-1:0]                      sq_out,
  output logic [bfi_pkg::NormW-1:0]                    nm_out [3],
  output bfi_pkg::wres_t                               wr_out,
  output logic [2:0]                                   sneg_out,
  output logic                                         fneg_out,
  output logic [FRAC_BITS+bfi_pkg::DataW-1:0]          fmag_out,
  output logic                                         zero_out
);
  import bfi_pkg::*;

  localparam int SW   = 2 * DataW - FRAC_BITS + 2;
  localparam int MW   = SW;
  localparam int NC   = (MW + 7) / 8;
  localparam int LB   = $clog2(NC * 8);
  localparam int FMW  = FRAC_BITS + DataW;
  localparam int FMX  = (MW > FMW) ? MW : FMW;
  localparam int SqPW = 2 * NormW;
  localparam logic [FMX-1:0] FCap = FMX'(1) << (FRAC_BITS + DataW - 1);

  typedef struct packed {
    wres_t          wr;
    logic [2:0]     sneg;
    logic           fneg;
    logic [FMW-1:0] fmag;
  } side_t;

  // stage 5 comb
  logic [MW-1:0]   mag_c [3];
  logic [MW-1:0]   m_c;
  logic [MW-1:0]   fabs_c;
  logic [FMX-1:0]  fa_c;
  side_t           side_c;

  logic            v5, v6, v7, v8, v9;
  logic [MW-1:0]   mag5 [3], mag6 [3], mag7 [3];
  logic [MW-1:0]   m5;
  side_t           side5, side6, side7, side8, side9;

  logic [NC*8-1:0] mpad;
  logic [2:0]      pos_c [NC];
  logic [NC-1:0]   any6;
  logic [2:0]      pos6 [NC];
  logic [LB-1:0]   lead_c;
  logic            zero_c;
  logic [LB-1:0]   lead7;
  logic            zero7, zero8, zero9;
  logic [MW-1:0]   shv [3];
  logic [NormW-1:0] nm8 [3], nm9 [3];
  logic [SqPW-1:0] sqp9 [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = s_in[k][SW-1] ? MW'(-s_in[k]) : MW'(s_in[k]);
    end
    m_c = mag_c[0];
    if (mag_c[1] > m_c) m_c = mag_c[1];
    if (mag_c[2] > m_c) m_c = mag_c[2];
    fabs_c = f_in[SW-1] ? MW'(-f_in) : MW'(f_in);
    fa_c   = FMX'(fabs_c);
    // larger force magnitudes saturate the result anyway
    if (fa_c > FCap) fa_c = FCap;
    side_c.wr   = wr_in;
    side_c.sneg = {s_in[2][SW-1], s_in[1][SW-1], s_in[0][SW-1]};
    side_c.fneg = f_in[SW-1];
    side_c.fmag = fa_c[FMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v_out <= 1'b0;
    end else if (en) begin
      v5 <= v_in; v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8; v_out <= v9;
    end
  end

  assign mpad = (NC*8)'(m5);

  // highest set bit within each byte
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      pos_c[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (mpad[c*8 + b]) pos_c[c] = 3'(b);
      end
    end
  end

  // leading one: pick the top byte of the per-byte scan, then shift to the normalized position
  always_comb begin
    lead_c = '0;
    zero_c = 1'b1;
    for (int c = 0; c < NC; c++) begin
      if (any6[c]) begin
        lead_c = LB'(c * 8) + LB'(pos6[c]);
        zero_c = 1'b0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (lead7 >= LB'(NormPos)) begin
        shv[k] = mag7[k] >> (lead7 - LB'(NormPos));
      end else begin
        shv[k] = mag7[k] << (LB'(NormPos) - lead7);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag5  <= mag_c;
      m5    <= m_c;
      side5 <= side_c;

      for (int c = 0; c < NC; c++) begin
        any6[c] <= |mpad[c*8 +: 8];
        pos6[c] <= pos_c[c];
      end
      mag6  <= mag5;
      side6 <= side5;

      lead7 <= lead_c;
      zero7 <= zero_c;
      mag7  <= mag6;
      side7 <= side6;

      for (int k = 0; k < 3; k++) begin
        nm8[k] <= shv[k][NormW-1:0];
      end
      zero8 <= zero7;
      side8 <= side7;

      for (int k = 0; k < 3; k++) begin
        sqp9[k] <= SqPW'(nm8[k]) * SqPW'(nm8[k]);
      end
      nm9   <= nm8;
      zero9 <= zero8;
      side9 <= side8;

      sq_out   <= SqW'(sqp9[0]) + SqW'(sqp9[1]) + SqW'(sqp9[2]);
      nm_out   <= nm9;
      zero_out <= zero9;
      wr_out   <= side9.wr;
      sneg_out <= side9.sneg;
      fneg_out <= side9.fneg;
      fmag_out <= side9.fmag;
    end
  end

endmodule

// ===== sv/bfi_recip.sv =====
// ----------------------------------------------------------------------------
// bfi_recip: length, unit vector and force scaling
// Pipelined square root (one root bit a stage), restoring division (one
// quotient bit a stage), split multiply and saturation.
// ----------------------------------------------------------------------------
module bfi_recip #(
  parameter int FRAC_BITS = bfi_pkg::FracBitsDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                v_in,
  input  logic [bfi_pkg::SqW-1:0]             sq_in,
  input  logic [bfi_pkg::NormW-1:0]           nm_in [3],
  input  bfi_pkg::wres_t                      wr_in,
  input  logic [2:0]                          sneg_in,
  input  logic                                fneg_in,
  input  logic [FRAC_BITS+bfi_pkg::DataW-1:0] fmag_in,
  input  logic                                zero_in,
  output logic                                v_out,
  output bfi_pkg::wres_t                      wr_out,
  output bfi_pkg::word_t [2:0]                field_out
);
  import bfi_pkg::*;

  localparam int FMW = FRAC_BITS + DataW;
  localparam int RW  = LenW + 3;
  localparam int QW  = FRAC_BITS + 1;
  localparam int DW  = LenW + 1;
  localparam int H   = (FMW + 1) / 2;
  localparam int LOW = QW + H;
  localparam int HIW = QW + FMW - H;
  localparam int PMW = QW + FMW;

  typedef struct packed {
    wres_t          wr;
    logic [2:0]     sneg;
    logic           fneg;
    logic [FMW-1:0] fmag;
    logic           zero;
  } side_t;

  side_t side_in;
  assign side_in = '{wr: wr_in, sneg: sneg_in, fneg: fneg_in, fmag: fmag_in, zero: zero_in};

  // square root stages
  logic             qv    [LenW];
  logic [RW-1:0]    qrem  [LenW];
  logic [LenW-1:0]  qroot [LenW];
  logic [SqW-1:0]   qn    [LenW];
  logic [NormW-1:0] qnm   [LenW][3];
  side_t            qside [LenW];

  for (genvar i = 0; i < LenW; i++) begin : g_sqrt
    logic             v_c;
    logic [RW-1:0]    rem_c;
    logic [LenW-1:0]  root_c;
    logic [SqW-1:0]   n_c;
    logic [NormW-1:0] nm_c [3];
    side_t            side_c;
    logic [RW-1:0]    r2;
    logic [RW-1:0]    trial;

    if (i == 0) begin : g_src
      assign v_c    = v_in;
      assign rem_c  = '0;
      assign root_c = '0;
      assign n_c    = sq_in;
      assign nm_c   = nm_in;
      assign side_c = side_in;
    end else begin : g_src
      assign v_c    = qv[i-1];
      assign rem_c  = qrem[i-1];
      assign root_c = qroot[i-1];
      assign n_c    = qn[i-1];
      assign nm_c   = qnm[i-1];
      assign side_c = qside[i-1];
    end

    assign r2    = {rem_c[RW-3:0], n_c[SqW-1 -: 2]};
    assign trial = RW'({root_c, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[i] <= 1'b0;
      end else if (en) begin
        qv[i] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (r2 >= trial) begin
          qrem[i]  <= r2 - trial;
          qroot[i] <= {root_c[LenW-2:0], 1'b1};
        end else begin
          qrem[i]  <= r2;
          qroot[i] <= {root_c[LenW-2:0], 1'b0};
        end
        qn[i]    <= n_c << 2;
        qnm[i]   <= nm_c;
        qside[i] <= side_c;
      end
    end
  end

  // division stages: unit = (nm << FRAC_BITS) / len, nm <= len
  logic            dv    [QW];
  logic [DW-1:0]   drem  [QW][3];
  logic [QW-1:0]   dq    [QW][3];
  logic [LenW-1:0] dlen  [QW];
  side_t           dside [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic            v_c;
    logic [DW-1:0]   rem_c [3];
    logic [QW-1:0]   q_c   [3];
    logic            bit_c [3];
    logic [LenW-1:0] len_c;
    side_t           side_c;
    logic [DW-1:0]   r2    [3];

    if (j == 0) begin : g_src
      assign v_c    = qv[LenW-1];
      assign len_c  = qroot[LenW-1];
      assign side_c = qside[LenW-1];
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign rem_c[k] = DW'(qnm[LenW-1][k] >> 1);
        assign q_c[k]   = '0;
        assign bit_c[k] = qnm[LenW-1][k][0];
      end
    end else begin : g_src
      assign v_c    = dv[j-1];
      assign len_c  = dlen[j-1];
      assign side_c = dside[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign rem_c[k] = drem[j-1][k];
        assign q_c[k]   = dq[j-1][k];
        assign bit_c[k] = 1'b0;
      end
    end

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r2[k] = {rem_c[k][DW-2:0], bit_c[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j] <= 1'b0;
      end else if (en) begin
        dv[j] <= v_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (r2[k] >= DW'(len_c)) begin
            drem[j][k] <= r2[k] - DW'(len_c);
            dq[j][k]   <= {q_c[k][QW-2:0], 1'b1};
          end else begin
            drem[j][k] <= r2[k];
            dq[j][k]   <= {q_c[k][QW-2:0], 1'b0};
          end
        end
        dlen[j]  <= len_c;
        dside[j] <= side_c;
      end
    end
  end

  // unit times force magnitude, split in two partial products
  logic           mv;
  logic [LOW-1:0] plo [3];
  logic [HIW-1:0] phi [3];
  side_t          mside;
  logic [PMW-1:0] prod [3];
  logic           big  [3];
  logic [30:0]    rsm  [3];
  word_t          fld  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv    <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      mv    <= dv[QW-1];
      v_out <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        plo[k] <= LOW'(dq[QW-1][k]) * LOW'(dside[QW-1].fmag[H-1:0]);
        phi[k] <= HIW'(dq[QW-1][k]) * HIW'(dside[QW-1].fmag[FMW-1:H]);
      end
      mside <= dside[QW-1];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (PMW'(phi[k]) << H) + PMW'(plo[k]);
      big[k]  = |prod[k][PMW-1:FRAC_BITS+31];
      rsm[k]  = prod[k][FRAC_BITS+30:FRAC_BITS];
      if (mside.zero) begin
        fld[k] = '0;
      end else if (mside.sneg[k] ^ mside.fneg) begin
        fld[k] = big[k] ? {1'b1, {(DataW-1){1'b0}}} : -DataW'(rsm[k]);
      end else begin
        fld[k] = big[k] ? {1'b0, {(DataW-1){1'b1}}} : DataW'(rsm[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_out <= mside.wr;
      for (int k = 0; k < 3; k++) begin
        field_out[k] <= fld[k];
      end
    end
  end

endmodule

// ===== sv/tetra_barycentric_field_interp.sv =====
// ----------------------------------------------------------------------------
// tetra_barycentric_field_interp: tetrahedron weights and field interpolation
// Streaming block that holds one inverse barycentric matrix and four vertex
// directions with force factors, and answers point queries.
// ----------------------------------------------------------------------------
// Takes one request per clock while s_tready is high and returns one result
// per clock while m_tready is high. A request with tuser operation 0 loads
// matrix row <slot> from tdata (four Q16.16 coefficients), operation 1 loads
// vertex <slot> direction x, y, z and force, operation 2 queries the point
// x, y, z, and operation 3 is dropped. Only queries give a result; loads and
// queries stay in order, so a query always sees every load sent before it.
// Most depth is in the square root of the blend length (31 stages, one root
// bit each) and the unit-vector division (FRAC_BITS + 1 stages, one quotient
// bit each) ahead of the Q16.16 field. An output register plus a one-entry
// skid stage keep the input open while one result waits on m_tready.
// Reading a matrix row or vertex that was never loaded gives arbitrary data.
// ----------------------------------------------------------------------------
module tetra_barycentric_field_interp #(
  parameter int FRAC_BITS = bfi_pkg::FracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // value_a, value_b, value_c, value_d
  input  logic [bfi_pkg::InDataW-1:0]   s_tdata,
  // operation, slot
  input  logic [bfi_pkg::InUserW-1:0]   s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // weight_0, weight_1, weight_2, weight_3, field_x, field_y, field_z
  output logic [bfi_pkg::OutDataW-1:0]  m_tdata,
  // inside_res
  output logic                          m_tuser
);
  import bfi_pkg::*;

  localparam int SW  = 2 * DataW - FRAC_BITS + 2;
  localparam int FMW = FRAC_BITS + DataW;

  // whole pipeline moves while the skid stage is free
  logic en;

  logic  in_v;
  item_t in_item;

  logic  w_v;
  wres_t w_wr;
  item_t w_item;

  logic                 b_v;
  logic signed [SW-1:0] b_s [3];
  logic signed [SW-1:0] b_f;
  wres_t                b_wr;

  logic             n_v;
  logic [SqW-1:0]   n_sq;
  logic [NormW-1:0] n_nm [3];
  wres_t            n_wr;
  logic [2:0]       n_sneg;
  logic             n_fneg;
  logic [FMW-1:0]   n_fmag;
  logic             n_zero;

  logic         p_v;
  wres_t        p_wr;
  word_t [2:0]  p_field;

  logic  o_valid, skid_valid;
  ores_t o_data, skid_data, p_data;

  assign en       = ~skid_valid;
  assign s_tready = en;

  // input request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_item.op   <= s_tuser[1:0];
      in_item.slot <= s_tuser[3:2];
      in_item.a    <= s_tdata[DataW-1:0];
      in_item.b    <= s_tdata[2*DataW-1:DataW];
      in_item.c    <= s_tdata[3*DataW-1:2*DataW];
      in_item.d    <= s_tdata[4*DataW-1:3*DataW];
    end
  end

  // weights: matrix row loads are written and consumed here
  bfi_weight #(.FRAC_BITS(FRAC_BITS)) u_weight (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (in_v),
    .item_in  (in_item),
    .v_out    (w_v),
    .wr_out   (w_wr),
    .item_out (w_item)
  );

  // blends: vertex loads are written and consumed here
  bfi_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .v_in    (w_v),
    .wr_in   (w_wr),
    .item_in (w_item),
    .v_out   (b_v),
    .s_out   (b_s),
    .f_out   (b_f),
    .wr_out  (b_wr)
  );

  bfi_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (b_v),
    .s_in     (b_s),
    .f_in     (b_f),
    .wr_in    (b_wr),
    .v_out    (n_v),
    .sq_out   (n_sq),
    .nm_out   (n_nm),
    .wr_out   (n_wr),
    .sneg_out (n_sneg),
    .fneg_out (n_fneg),
    .fmag_out (n_fmag),
    .zero_out (n_zero)
  );

  bfi_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v_in      (n_v),
    .sq_in     (n_sq),
    .nm_in     (n_nm),
    .wr_in     (n_wr),
    .sneg_in   (n_sneg),
    .fneg_in   (n_fneg),
    .fmag_in   (n_fmag),
    .zero_in   (n_zero),
    .v_out     (p_v),
    .wr_out    (p_wr),
    .field_out (p_field)
  );

  assign p_data = '{f: p_field, wr: p_wr};

  // output register with skid: a result leaving the pipeline while the
  // output is stalled parks in the skid stage, which then holds the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!o_valid || m_tready) begin
      if (skid_valid) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        o_valid <= p_v;
      end
    end else if (p_v && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || m_tready) begin
      o_data <= skid_valid ? skid_data : p_data;
    end else if (p_v && en) begin
      skid_data <= p_data;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_data.f, o_data.wr.w};
  assign m_tuser  = o_data.wr.in_tet;

  // the skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> o_valid)
    else $error("skid stage full with output register empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(o_valid && !m_tready))
    else $error("skid stage filled while output was free");

  // inside flag agrees with the weight signs
  a_inside_sign: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (!m_tdata[DataW-1] && !m_tdata[2*DataW-1] &&
                               !m_tdata[3*DataW-1] && !m_tdata[4*DataW-1]))
    else $error("inside flag set with a negative weight");

endmodule

// ===== test/tetra_barycentric_field_interp_tb.sv =====
// ----------------------------------------------------------------------------
// tetra_barycentric_field_interp_tb: self-checking bench for the interpolator
// Loads matrix rows and vertices, streams point queries with random gaps on
// both sides, predicts weights and field per query and checks every result.
// ----------------------------------------------------------------------------
module tetra_barycentric_field_interp_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfi_pkg::*;

  localparam logic [1:0] OpDrop = 2'd3;
  localparam int Frac = FracBitsDef;
  localparam longint MaxCycles = 600000;

  // shadow of the block state plus queue of pending query answers
  class field_board;
    word_t mat[16];
    word_t dir[12];
    word_t frc[4];
    logic [OutDataW:0] answers[$];  // {inside, tdata}
    int errors;

    function longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> Frac;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function logic [63:0] root(logic [63:0] n);
      logic [63:0] r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt = bt >> 2;
      while (bt != 0) begin
        if (n >= r + bt) begin
          n = n - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
      return r;
    endfunction

    function void note(item_t it);
      longint w[4], s[3], fblend, fld[3];
      logic [63:0] mag[3], m, fmag, sq, len, unit, r;
      logic [127:0] prod;
      logic in_tet;
      logic [OutDataW-1:0] td;
      case (it.op)
        OpLoadRow: begin
          mat[it.slot*4] = it.a; mat[it.slot*4+1] = it.b;
          mat[it.slot*4+2] = it.c; mat[it.slot*4+3] = it.d;
          return;
        end
        OpLoadVertex: begin
          dir[it.slot*3] = it.a; dir[it.slot*3+1] = it.b;
          dir[it.slot*3+2] = it.c; frc[it.slot] = it.d;
          return;
        end
        OpQuery: ;
        default: return;
      endcase
      in_tet = 1'b1;
      for (int i = 0; i < 4; i++) begin
        w[i] = sat(fmul(mat[i*4], it.a) + fmul(mat[i*4+1], it.b) +
                   fmul(mat[i*4+2], it.c) + longint'(mat[i*4+3]));
        if (w[i] < 0) in_tet = 1'b0;
      end
      m = 0;
      for (int k = 0; k < 3; k++) begin
        s[k] = 0;
        for (int i = 0; i < 4; i++) s[k] += fmul(dir[i*3+k], w[i]);
        mag[k] = s[k] < 0 ? -s[k] : s[k];
        if (mag[k] > m) m = mag[k];
      end
      fblend = 0;
      for (int i = 0; i < 4; i++) fblend += fmul(frc[i], w[i]);
      fmag = fblend < 0 ? -fblend : fblend;
      if (m == 0) begin
        fld[0] = 0; fld[1] = 0; fld[2] = 0;
      end else begin
        // bring the largest magnitude into [2^29, 2^30)
        while (m >= (64'd1 << 30)) begin
          m = m >> 1;
          for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        while (m < (64'd1 << 29)) begin
          m = m << 1;
          for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        sq = 0;
        for (int k = 0; k < 3; k++) sq += mag[k] * mag[k];
        len = root(sq);
        for (int k = 0; k < 3; k++) begin
          unit = (mag[k] << Frac) / len;
          prod = 128'(unit) * 128'(fmag);
          r = (prod >> 64) != 0 ? (64'd1 << 40) : 64'(prod >> Frac);
          if ((s[k] < 0) != (fblend < 0))
            fld[k] = r >= (64'd1 << 31) ? -64'sd2147483648 : -longint'(r);
          else
            fld[k] = r > 64'd2147483647 ? 64'sd2147483647 : longint'(r);
        end
      end
      td = {fld[2][31:0], fld[1][31:0], fld[0][31:0],
            w[3][31:0], w[2][31:0], w[1][31:0], w[0][31:0]};
      answers.push_back({in_tet, td});
    endfunction

    function void check(logic [OutDataW-1:0] td, logic ins);
      logic [OutDataW:0] ex;
      string names[7] = '{"weight_0", "weight_1", "weight_2", "weight_3",
                          "field_x", "field_y", "field_z"};
      if (answers.size() == 0) begin
        $error("result with no pending query");
        errors++;
        return;
      end
      ex = answers.pop_front();
      if (ex[OutDataW] !== ins) begin
        $error("inside_res expected %0d actual %0d", ex[OutDataW], ins);
        errors++;
      end
      for (int f = 0; f < 7; f++)
        if (ex[f*32 +: 32] !== td[f*32 +: 32]) begin
          $error("%s expected %0d actual %0d", names[f],
                 $signed(ex[f*32 +: 32]), $signed(td[f*32 +: 32]));
          errors++;
        end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [InDataW-1:0] s_tdata = '0;
  logic [InUserW-1:0] s_tuser = '0;
  logic s_tready, m_tvalid, m_tuser;
  logic [OutDataW-1:0] m_tdata;

  int send_idle = 0, recv_idle = 0;
  bit stall_req = 0;
  longint cycles = 0;
  field_board board = new();

  tetra_barycentric_field_interp i_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (stall_req && hold == 0) begin
        stall_req = 0;
        hold = 500;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check(m_tdata, m_tuser);

  task automatic push(input logic [1:0] op, input logic [1:0] slot,
                      input word_t a, input word_t b, input word_t c, input word_t d);
    item_t it;
    it = '{op: op, slot: slot, a: a, b: b, c: c, d: d};
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {d, c, b, a};
    s_tuser <= {slot, op};
    do @(posedge clk); while (!s_tready);
    board.note(it);
  endtask

  function automatic word_t pick_val();
    case ($urandom_range(5))
      0: return $urandom();
      1: begin
        case ($urandom_range(4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          default: return 32'h00010000;
        endcase
      end
      2: return $signed($urandom_range(16777215)) - 32'sd8388608;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  // small coefficients keep weights near [0, 1] so inside gets exercised
  function automatic word_t pick_coef();
    if ($urandom_range(3) == 0) return pick_val();
    return $signed($urandom_range(131071)) - 32'sd65536;
  endfunction

  task automatic load_all();
    for (int r = 0; r < 4; r++)
      push(OpLoadRow, 2'(r), pick_coef(), pick_coef(), pick_coef(), pick_coef());
    for (int v = 0; v < 4; v++)
      push(OpLoadVertex, 2'(v), pick_val(), pick_val(), pick_val(), pick_val());
  endtask

  initial begin
    int op_pick;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity-like matrix, directions (v, 1, 0), edge points
    push(OpLoadRow, 2'd0, 32'h00010000, 0, 0, 0);
    push(OpLoadRow, 2'd1, 0, 32'h00010000, 0, 0);
    push(OpLoadRow, 2'd2, 0, 0, 32'h00010000, 0);
    push(OpLoadRow, 2'd3, 32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h00010000);
    for (int v = 0; v < 4; v++)
      push(OpLoadVertex, 2'(v), 32'h00010000 * v, 32'h00010000, 0, 32'h00020000);
    push(OpQuery, 2'd0, 32'h00004000, 32'h00004000, 32'h00004000, 0);
    push(OpQuery, 2'd3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
    push(OpQuery, 2'd1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
    push(OpQuery, 2'd2, 0, 0, 0, 0);
    push(OpDrop, 2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    // zero-length blend: all directions zero
    for (int v = 0; v < 4; v++)
      push(OpLoadVertex, 2'(v), 0, 0, 0, 32'h7fffffff);
    push(OpQuery, 2'd0, 32'h00008000, 32'h00002000, 32'h00001000, 0);
    // extreme coefficients and force
    push(OpLoadRow, 2'd1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push(OpLoadVertex, 2'd2, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    push(OpQuery, 2'd0, 32'h7fffffff, 32'h80000000, 32'h00010000, 0);
    push(OpQuery, 2'd0, 32'hffffffff, 32'h00000001, 32'h80000000, 0);

    // random: mostly queries against fresh geometry, some loads and drops
    load_all();
    for (int n = 0; n < 1420; n++) begin
      if (n == 0) begin send_idle = 26; recv_idle = 49; end
      if (n == 470) begin send_idle = 49; recv_idle = 26; end
      if (n == 940) begin send_idle = 0; recv_idle = 0; stall_req = 1; end
      op_pick = $urandom_range(99);
      if (op_pick < 70)
        push(OpQuery, 2'($urandom()), pick_val(), pick_val(), pick_val(), $urandom());
      else if (op_pick < 82)
        push(OpLoadRow, 2'($urandom()), pick_coef(), pick_coef(), pick_coef(),
             pick_coef());
      else if (op_pick < 95)
        push(OpLoadVertex, 2'($urandom()), pick_val(), pick_val(), pick_val(),
             pick_val());
      else
        push(OpDrop, 2'($urandom()), $urandom(), $urandom(), $urandom(), $urandom());
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    while (board.answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
